/* src/nns_pkg.sv */
`default_nettype none

package nns_pkg;

  // Default number of node slots.
  localparam int NODES_DEF = 1024;

  // Planar search: one cell in the chain for each axis.
  localparam int AXES = 2;

  // Field widths of the streams and the register.
  localparam int COORD_W   = 16;
  localparam int INDEX_W   = 10;
  localparam int COUNT_W   = 11;
  localparam int SQ_W      = 2 * COORD_W;
  localparam int DIST_W    = SQ_W + 2;
  // Wide enough to hold any slot count up to 65536.
  localparam int CNT_EXT_W = 17;

  // Stream packing.
  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 48;

  // Configuration port.
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic [COUNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

  // Item kinds carried on tuser.
  localparam logic KIND_LOAD  = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [AXES-1:0] coord_vec_t;
  typedef logic [DIST_W-1:0] dist_t;

  // Control travelling alongside each node through the cell chain.
  typedef struct packed {
    logic valid;
    logic last;
  } beat_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

`default_nettype wire

/* src/nns_store.sv */
`default_nettype none

// Coordinate memory: one write port for loads, one registered read port for the scan.
module nns_store #(
  parameter int NODES = nns_pkg::NODES_DEF
) (
  input  wire                           clk,
  input  wire                           we,
  input  wire  [$clog2(NODES)-1:0]      waddr,
  input  nns_pkg::coord_vec_t           wdata,
  input  wire                           re,
  input  wire  [$clog2(NODES)-1:0]      raddr,
  output nns_pkg::coord_vec_t           rdata
);

  nns_pkg::coord_vec_t mem [NODES];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* src/nns_axis_cell.sv */
`default_nettype none

// One cell of the distance chain. It takes the lowest coordinate of the incoming
// vector, adds the square of its distance to the target on that axis to the
// running sum, and hands the remaining coordinates on shifted down by one.
// Three register stages: magnitude, square, accumulate.
module nns_axis_cell #(
  parameter int IDX_W = $clog2(nns_pkg::NODES_DEF)
) (
  input  wire                   clk,
  input  wire                   rst,
  input  nns_pkg::beat_ctrl_t   in_ctrl,
  input  wire  [IDX_W-1:0]      in_idx,
  input  nns_pkg::coord_vec_t   in_coord,
  input  nns_pkg::dist_t        in_sum,
  input  nns_pkg::coord_t       target,
  output nns_pkg::beat_ctrl_t   out_ctrl,
  output logic [IDX_W-1:0]      out_idx,
  output nns_pkg::coord_vec_t   out_coord,
  output nns_pkg::dist_t        out_sum
);

  localparam int CW = nns_pkg::COORD_W;

  logic signed [CW:0]     diff;
  logic        [CW:0]     mag_full;
  nns_pkg::coord_vec_t    shifted;

  nns_pkg::beat_ctrl_t    s1_ctrl;
  logic [IDX_W-1:0]       s1_idx;
  nns_pkg::coord_vec_t    s1_coord;
  nns_pkg::dist_t         s1_sum;
  logic [CW-1:0]          s1_mag;

  nns_pkg::beat_ctrl_t    s2_ctrl;
  logic [IDX_W-1:0]       s2_idx;
  nns_pkg::coord_vec_t    s2_coord;
  nns_pkg::dist_t         s2_sum;
  logic [nns_pkg::SQ_W-1:0] s2_sq;

  always_comb begin
    diff     = {target[CW-1], target} - {in_coord[0][CW-1], in_coord[0]};
    mag_full = diff[CW] ? (~diff + 1'b1) : diff;
    for (int j = 0; j < nns_pkg::AXES - 1; j++) begin
      shifted[j] = in_coord[j + 1];
    end
    shifted[nns_pkg::AXES - 1] = '0;
  end

  // Valid flags are cleared by reset; payload is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctrl  <= '0;
      s2_ctrl  <= '0;
      out_ctrl <= '0;
    end else begin
      s1_ctrl  <= in_ctrl;
      s2_ctrl  <= s1_ctrl;
      out_ctrl <= s2_ctrl;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx    <= in_idx;
    s1_coord  <= shifted;
    s1_sum    <= in_sum;
    s1_mag    <= mag_full[CW-1:0];

    s2_idx    <= s1_idx;
    s2_coord  <= s1_coord;
    s2_sum    <= s1_sum;
    s2_sq     <= s1_mag * s1_mag;

    out_idx   <= s2_idx;
    out_coord <= s2_coord;
    out_sum   <= s2_sum + nns_pkg::DIST_W'(s2_sq);
  end

endmodule

`default_nettype wire

/* src/nearest_node_search.sv */
`default_nettype none

// Nearest node search over up to NODES stored planar points. A load transaction
// (tuser 0) writes one node's Q8.8 x,y into the slot given by node_index;
// slots at NODES or above are ignored. A query transaction (tuser 1) carries a
// target position and yields one result: the index of the closest node among
// slots 0 .. node_count-1 and the exact squared distance to it, with the lowest
// index winning a tie. A node_count of zero scans slot 0 only, and a count above
// NODES scans all NODES slots. A query occupies the block until its result is
// registered: the coordinate memory is read at one address per cycle over the
// clamped node count, and each node then passes through a chain of two distance
// cells (three stages each) before the running minimum is updated. Slots must be
// loaded before a query reaches them; a slot that was never written gives an
// undefined answer. No clearing pass is needed after reset. The result sits in an
// output register, so the next transaction is taken while the previous result
// still waits on the master side.
module nearest_node_search #(
  parameter int NODES = nns_pkg::NODES_DEF
) (
  input  wire                              clk,
  input  wire                              rst,

  // Input stream.
  input  wire                              s_tvalid,
  output logic                             s_tready,
  // node_index [9:0], pos_x [25:10], pos_y [41:26], zero [47:42]
  input  wire  [nns_pkg::S_TDATA_W-1:0]    s_tdata,
  // kind [0]
  input  wire                              s_tuser,

  // Result stream.
  output logic                             m_tvalid,
  input  wire                              m_tready,
  // nearest_index [9:0], nearest_dist_sq [43:10], zero [47:44]
  output logic [nns_pkg::M_TDATA_W-1:0]    m_tdata,

  // Configuration port.
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [nns_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire  [nns_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [nns_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  localparam int IDX_W = $clog2(NODES);
  localparam int AXES  = nns_pkg::AXES;
  localparam int XW    = nns_pkg::CNT_EXT_W;

  // Unpacked input fields.
  logic [nns_pkg::INDEX_W-1:0] in_node_index;
  nns_pkg::coord_t             in_pos_x;
  nns_pkg::coord_t             in_pos_y;

  assign in_node_index = s_tdata[9:0];
  assign in_pos_x      = s_tdata[25:10];
  assign in_pos_y      = s_tdata[41:26];

  logic in_accept;
  assign in_accept = s_tvalid && s_tready;

  // ---------------------------------------------------------------------
  // Configuration register. pready is tied high, so every write completes in
  // its access cycle. The register is selected by paddr[2]; other addresses
  // read as zero and ignore writes.
  // ---------------------------------------------------------------------
  logic [nns_pkg::COUNT_W-1:0] node_count;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= nns_pkg::NODE_COUNT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == nns_pkg::REG_NODE_COUNT) begin
      node_count <= pwdata[nns_pkg::COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == nns_pkg::REG_NODE_COUNT) ?
                  nns_pkg::APB_DATA_W'(node_count) : '0;

  // ---------------------------------------------------------------------
  // Control state machine.
  // ---------------------------------------------------------------------
  nns_pkg::state_t state;
  nns_pkg::state_t state_next;

  logic [IDX_W-1:0]     scan_addr;
  logic [IDX_W-1:0]     scan_last;
  nns_pkg::coord_vec_t  target;

  logic                 scan_en;
  logic                 scan_at_last;
  logic                 out_load;

  // End of the cell chain.
  nns_pkg::beat_ctrl_t  link_ctrl  [AXES+1];
  logic [IDX_W-1:0]     link_idx   [AXES+1];
  nns_pkg::coord_vec_t  link_coord [AXES+1];
  nns_pkg::dist_t       link_sum   [AXES+1];

  assign scan_at_last = (scan_addr == scan_last);

  always_comb begin
    state_next = state;
    unique case (state)
      nns_pkg::ST_IDLE: begin
        if (in_accept && s_tuser == nns_pkg::KIND_QUERY) begin
          state_next = nns_pkg::ST_SCAN;
        end
      end
      nns_pkg::ST_SCAN: begin
        if (scan_at_last) begin
          state_next = nns_pkg::ST_DRAIN;
        end
      end
      nns_pkg::ST_DRAIN: begin
        if (link_ctrl[AXES].valid && link_ctrl[AXES].last) begin
          state_next = nns_pkg::ST_FINISH;
        end
      end
      nns_pkg::ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          state_next = nns_pkg::ST_IDLE;
        end
      end
      default: state_next = nns_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    scan_en  = 1'b0;
    out_load = 1'b0;
    unique case (state)
      nns_pkg::ST_IDLE:   s_tready = 1'b1;
      nns_pkg::ST_SCAN:   scan_en  = 1'b1;
      nns_pkg::ST_DRAIN:  ;
      nns_pkg::ST_FINISH: out_load = !m_tvalid || m_tready;
      default:            ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= nns_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Scan range: a zero count scans slot 0, a count beyond NODES is clamped.
  logic [XW-1:0] cnt_ext;
  logic [XW-1:0] cnt_clamped;
  logic [XW-1:0] cnt_last;

  always_comb begin
    cnt_ext = XW'(node_count);
    if (cnt_ext == '0) begin
      cnt_clamped = XW'(1);
    end else if (cnt_ext > XW'(NODES)) begin
      cnt_clamped = XW'(NODES);
    end else begin
      cnt_clamped = cnt_ext;
    end
    cnt_last = cnt_clamped - XW'(1);
  end

  always_ff @(posedge clk) begin
    if (in_accept && s_tuser == nns_pkg::KIND_QUERY) begin
      scan_addr <= '0;
      scan_last <= cnt_last[IDX_W-1:0];
      target[0] <= in_pos_x;
      target[1] <= in_pos_y;
    end else if (scan_en && !scan_at_last) begin
      scan_addr <= scan_addr + 1'b1;
    end
  end

  // ---------------------------------------------------------------------
  // Coordinate memory.
  // ---------------------------------------------------------------------
  logic [XW-1:0]        load_idx_ext;
  logic                 mem_we;
  nns_pkg::coord_vec_t  mem_wdata;
  nns_pkg::coord_vec_t  mem_rdata;

  always_comb begin
    load_idx_ext = XW'(in_node_index);
    mem_we       = in_accept && s_tuser == nns_pkg::KIND_LOAD &&
                   load_idx_ext < XW'(NODES);
    mem_wdata[0] = in_pos_x;
    mem_wdata[1] = in_pos_y;
  end

  nns_store #(
    .NODES (NODES)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (load_idx_ext[IDX_W-1:0]),
    .wdata (mem_wdata),
    .re    (scan_en),
    .raddr (scan_addr),
    .rdata (mem_rdata)
  );

  // Control and index are registered alongside the read so that they line up with the data.
  nns_pkg::beat_ctrl_t rd_ctrl;
  logic [IDX_W-1:0]    rd_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ctrl <= '0;
    end else begin
      rd_ctrl.valid <= scan_en;
      rd_ctrl.last  <= scan_en && scan_at_last;
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_addr;
  end

  // ---------------------------------------------------------------------
  // Distance chain: one cell for each axis, the running sum passed along.
  // ---------------------------------------------------------------------
  assign link_ctrl[0]  = rd_ctrl;
  assign link_idx[0]   = rd_idx;
  assign link_coord[0] = mem_rdata;
  assign link_sum[0]   = '0;

  for (genvar k = 0; k < AXES; k++) begin : g_cell
    nns_axis_cell #(
      .IDX_W (IDX_W)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_ctrl   (link_ctrl[k]),
      .in_idx    (link_idx[k]),
      .in_coord  (link_coord[k]),
      .in_sum    (link_sum[k]),
      .target    (target[k]),
      .out_ctrl  (link_ctrl[k+1]),
      .out_idx   (link_idx[k+1]),
      .out_coord (link_coord[k+1]),
      .out_sum   (link_sum[k+1])
    );
  end

  // ---------------------------------------------------------------------
  // Running minimum. The first node of a scan always loads; after that a
  // strictly smaller distance is needed, which keeps the lowest index on ties.
  // ---------------------------------------------------------------------
  logic [IDX_W-1:0] best_idx;
  nns_pkg::dist_t   best_dist;

  always_ff @(posedge clk) begin
    if (link_ctrl[AXES].valid &&
        (link_idx[AXES] == '0 || link_sum[AXES] < best_dist)) begin
      best_idx  <= link_idx[AXES];
      best_dist <= link_sum[AXES];
    end
  end

  // ---------------------------------------------------------------------
  // Result register.
  // ---------------------------------------------------------------------
  logic [XW-1:0]                best_idx_ext;
  logic [nns_pkg::INDEX_W-1:0]  res_index;
  nns_pkg::dist_t               res_dist;

  assign best_idx_ext = XW'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_index <= best_idx_ext[nns_pkg::INDEX_W-1:0];
      res_dist  <= best_dist;
    end
  end

  assign m_tdata = {4'b0000, res_dist, res_index};

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == nns_pkg::ST_SCAN) |-> (scan_addr <= scan_last))
    else $error("scan address ran past the last slot");

  a_chain_quiet_when_idle: assert property (@(posedge clk) disable iff (rst)
    link_ctrl[AXES].valid |-> (state == nns_pkg::ST_SCAN || state == nns_pkg::ST_DRAIN))
    else $error("node left the chain outside a scan");

  a_query_starts_scan: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tuser == nns_pkg::KIND_QUERY) |=> (state == nns_pkg::ST_SCAN))
    else $error("accepted query did not start a scan");

  a_finish_after_last: assert property (@(posedge clk) disable iff (rst)
    $rose(state == nns_pkg::ST_FINISH) |->
      ($past(link_ctrl[AXES].valid) && $past(link_ctrl[AXES].last)))
    else $error("result formed before the last node arrived");

  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_tuser == nns_pkg::KIND_LOAD && !m_tvalid) |=> !m_tvalid)
    else $error("load transaction produced a result");

endmodule

`default_nettype wire

/* verif/tb.sv */
module tb;
  import nns_pkg::*;

  // Coordinate extremes of the signed Q8.8 fields.
  localparam coord_t COORD_MIN = 16'sh8000;
  localparam coord_t COORD_MAX = 16'sh7FFF;
  // Squared distance from one corner of the coordinate square to the opposite corner.
  localparam dist_t DIST_FARTHEST = 34'd8589672450;

  // Byte addresses on the configuration port. Register index one does not exist, so a
  // write there must leave node_count untouched.
  localparam logic [APB_ADDR_W-1:0] NODE_COUNT_ADDR = {REG_NODE_COUNT, 2'b00};
  localparam logic [APB_ADDR_W-1:0] SPARE_ADDR      = 3'd4;

  localparam int PHASE_ITEMS   = 63;
  localparam int SETTLE_CYCLES = 16;
  // Covers a full scan over every slot, so that any result still in flight arrives.
  localparam int DRAIN_CYCLES  = NODES_DEF + 16;
  // Cycles without a single transaction before the run is declared hung.
  localparam int STALL_LIMIT   = 8 * (NODES_DEF + 9);

  typedef struct packed {
    logic [INDEX_W-1:0] slot;
    dist_t              dist_sq;
  } result_t;

  localparam result_t NO_RESULT = '0;

  typedef enum logic {ROW_ITEM, ROW_WRITE} row_op_t;

  // One step of the directed sequence: either a register write or a stream transaction.
  // Where typed is set, the expected result is given in the row and not predicted.
  typedef struct packed {
    row_op_t                 op;
    logic [APB_ADDR_W-1:0]   addr;
    logic [APB_DATA_W-1:0]   value;
    logic                    kind;
    logic [INDEX_W-1:0]      slot;
    coord_t                  x;
    coord_t                  y;
    logic                    typed;
    result_t                 want;
  } plan_row_t;

  localparam int PLAN_ROWS = 21;

  // The directed sequence walks from a node count of zero, where only slot 0 is scanned,
  // through small counts with ties and corner-to-corner distances, to a write at the
  // unused register address and a load into slot 1023, beyond the count.
  plan_row_t directed_plan [PLAN_ROWS] = '{
    '{ROW_WRITE, NODE_COUNT_ADDR, 32'h0000_0000, KIND_LOAD, '0, '0, '0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, '0, KIND_LOAD, 10'd0, COORD_MIN, COORD_MIN, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, '0, KIND_QUERY, 10'd1023, COORD_MAX, COORD_MAX, 1'b1,
      '{10'd0, DIST_FARTHEST}},
    '{ROW_ITEM, '0, '0, KIND_QUERY, 10'd0, COORD_MIN, COORD_MIN, 1'b1, '{10'd0, 34'd0}},
    '{ROW_ITEM, '0, '0, KIND_LOAD, 10'd1, COORD_MAX, COORD_MAX, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, '0, KIND_QUERY, 10'd1, COORD_MAX, COORD_MAX, 1'b1,
      '{10'd0, DIST_FARTHEST}},
    '{ROW_WRITE, NODE_COUNT_ADDR, 32'hFFFF_F802, KIND_LOAD, '0, '0, '0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, '0, KIND_QUERY, 10'd512, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, '0, KIND_QUERY, 10'd3, COORD_MAX, COORD_MAX, 1'b1, '{10'd1, 34'd0}},
    '{ROW_ITEM, '0, '0, KIND_LOAD, 10'd2, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, '0, KIND_LOAD, 10'd3, 16'sd0, 16'sd0, 1'b0, NO_RESULT},
    '{ROW_WRITE, NODE_COUNT_ADDR, 32'h0000_0004, KIND_LOAD, '0, '0, '0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, '0, KIND_QUERY, 10'd682, 16'sd0, 16'sd0, 1'b1, '{10'd2, 34'd0}},
    '{ROW_ITEM, '0, '0, KIND_QUERY, 10'd341, 16'sd256, -16'sd256, 1'b1,
      '{10'd2, 34'd131072}},
    '{ROW_ITEM, '0, '0, KIND_LOAD, 10'd3, 16'sd1, 16'sd1, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, '0, KIND_QUERY, 10'd0, 16'sd1, 16'sd1, 1'b1, '{10'd3, 34'd0}},
    '{ROW_WRITE, SPARE_ADDR, 32'h0000_0001, KIND_LOAD, '0, '0, '0, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, '0, KIND_QUERY, 10'd7, COORD_MIN, COORD_MAX, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, '0, KIND_QUERY, 10'd1023, 16'sd1, 16'sd1, 1'b1, '{10'd3, 34'd0}},
    '{ROW_ITEM, '0, '0, KIND_LOAD, 10'd1023, COORD_MAX, COORD_MIN, 1'b0, NO_RESULT},
    '{ROW_ITEM, '0, '0, KIND_QUERY, 10'd1000, COORD_MAX, COORD_MIN, 1'b0, NO_RESULT}
  };

  // Node counts of the random phases; each is written with random upper bits in pwdata.
  int phase_counts [8] = '{1, 0, 9, 24, 3, 64, 16, 2};

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  // node_index [9:0], pos_x [25:10], pos_y [41:26], zero [47:42]
  logic [S_TDATA_W-1:0]   s_tdata  = '0;
  // kind [0]
  logic                   s_tuser  = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // nearest_index [9:0], nearest_dist_sq [43:10], zero [47:44]
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   psel     = 1'b0;
  logic                   penable  = 1'b0;
  logic                   pwrite   = 1'b0;
  logic [APB_ADDR_W-1:0]  paddr    = '0;
  logic [APB_DATA_W-1:0]  pwdata   = '0;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;

  // Our own copy of the block's state: the coordinate stores, which slots have been
  // written since reset, and the node_count register.
  coord_t                 node_x_copy [NODES_DEF];
  coord_t                 node_y_copy [NODES_DEF];
  bit                     slot_loaded [NODES_DEF];
  logic [COUNT_W-1:0]     count_setting;

  // Results owed by the block, oldest first.
  result_t                pending_results [$];
  result_t                seen_result;
  result_t                due_result;

  // When set, neither side inserts idle cycles.
  bit                     calm = 1'b0;

  int                     load_total;
  int                     query_total;
  int                     write_total;
  int                     checked_total;
  int                     register_mismatches;
  int                     result_mismatches;
  int                     stall_cycles;

  nearest_node_search uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Number of slots a query scans: a count of zero still scans slot 0, and any count
  // above the number of slots scans them all.
  function automatic int clamp_span(input logic [COUNT_W-1:0] count);
    if (count == 0) return 1;
    if (count > NODES_DEF) return NODES_DEF;
    return int'(count);
  endfunction

  // Linear search for the nearest stored node. The squared distance is formed exactly
  // in 64-bit arithmetic, and a strict less-than keeps the lowest index on a tie.
  function automatic result_t scan_nearest(input coord_t px, input coord_t py);
    result_t best;
    longint  best_dist;
    longint  dx;
    longint  dy;
    longint  d;
    best      = '0;
    best_dist = 0;
    for (int i = 0; i < clamp_span(count_setting); i++) begin
      dx = longint'(px) - longint'(node_x_copy[i]);
      dy = longint'(py) - longint'(node_y_copy[i]);
      d  = dx * dx + dy * dy;
      if (i == 0 || d < best_dist) begin
        best_dist = d;
        best.slot = INDEX_W'(i);
      end
    end
    best.dist_sq = dist_t'(best_dist);
    return best;
  endfunction

  // Coordinates are biased towards the extremes and towards a small cluster round the
  // origin, so that ties and the largest distances turn up often.
  function automatic coord_t rand_coord();
    case ($urandom_range(5))
      0: begin
        return COORD_MIN;
      end
      1: begin
        return COORD_MAX;
      end
      2: begin
        return coord_t'(int'($urandom_range(6)) - 3);
      end
      default: begin
        return coord_t'($urandom);
      end
    endcase
  endfunction

  // Presents one transaction on the input stream, holding it until it is accepted, and
  // then brings our copy of the state up to date. A query adds its expected result,
  // either the one given by the caller or the one that the search above finds.
  task automatic send_item(input logic kind, input logic [INDEX_W-1:0] slot,
                           input coord_t x, input coord_t y,
                           input logic typed, input result_t want);
    if (!calm) begin
      while ($urandom_range(99) < 26) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {{(S_TDATA_W - INDEX_W - 2 * COORD_W){1'b0}}, y, x, slot};
    do @(posedge clk); while (!s_tready);
    if (kind == KIND_LOAD) begin
      node_x_copy[slot] = x;
      node_y_copy[slot] = y;
      slot_loaded[slot] = 1'b1;
      load_total++;
    end else begin
      pending_results = {pending_results, (typed ? want : scan_nearest(x, y))};
      query_total++;
    end
  endtask

  // A query aimed now and then exactly at a stored node, so that a distance of zero
  // and duplicate nodes are hit; the ignored node_index field carries random bits.
  task automatic send_query(input int span);
    coord_t x;
    coord_t y;
    int     pick;
    if ($urandom_range(3) == 0) begin
      pick = $urandom_range(span - 1);
      x    = node_x_copy[pick];
      y    = node_y_copy[pick];
    end else begin
      x = rand_coord();
      y = rand_coord();
    end
    send_item(KIND_QUERY, INDEX_W'($urandom_range(NODES_DEF - 1)), x, y, 1'b0, NO_RESULT);
  endtask

  // Lets every owed result arrive, then the given number of cycles for a load still in the block.
  task automatic quiesce(input int cycles);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (cycles) @(posedge clk);
  endtask

  task automatic apb_read(input logic [APB_ADDR_W-1:0] addr,
                          output logic [APB_DATA_W-1:0] data);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    paddr  <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes a register once the block is idle, then reads node_count straight back in a
  // back-to-back transfer and checks it against our copy.
  task automatic program_count(input logic [APB_ADDR_W-1:0] addr,
                               input logic [APB_DATA_W-1:0] value);
    logic [APB_DATA_W-1:0] readback;
    quiesce(SETTLE_CYCLES);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    if (addr == NODE_COUNT_ADDR) count_setting = value[COUNT_W-1:0];
    write_total++;
    apb_read(NODE_COUNT_ADDR, readback);
    if (readback !== APB_DATA_W'(count_setting)) begin
      $display("%0t: node_count read back expected %0d got %0d", $time,
               count_setting, readback);
      register_mismatches++;
    end
  endtask

  // One random phase: set the count, load whatever the scan would reach that has not
  // been loaded yet, then mix loads anywhere in the store with queries.
  task automatic run_phase(input int count);
    int span;
    program_count(NODE_COUNT_ADDR, ($urandom & ~32'h7FF) | APB_DATA_W'(count));
    span = clamp_span(count_setting);
    for (int s = 0; s < span; s++) begin
      if (!slot_loaded[s]) begin
        send_item(KIND_LOAD, INDEX_W'(s), rand_coord(), rand_coord(), 1'b0, NO_RESULT);
      end
    end
    repeat (PHASE_ITEMS) begin
      if ($urandom_range(99) < 40) begin
        send_item(KIND_LOAD,
                  ($urandom_range(3) == 0) ? INDEX_W'($urandom_range(NODES_DEF - 1))
                                           : INDEX_W'($urandom_range(span - 1)),
                  rand_coord(), rand_coord(), 1'b0, NO_RESULT);
      end else begin
        send_query(span);
      end
    end
  endtask

  // Result side: the ready line stalls at random outside the calm phase, and every
  // accepted result is compared field by field with the oldest expectation.
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 26);
    if (!rst && m_tvalid && m_tready) begin
      seen_result.slot    = m_tdata[INDEX_W-1:0];
      seen_result.dist_sq = m_tdata[INDEX_W +: DIST_W];
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, nothing expected, got index %0d dist %0d",
                 $time, seen_result.slot, seen_result.dist_sq);
        result_mismatches++;
      end else begin
        due_result = pending_results.pop_front();
        checked_total++;
        if (seen_result.slot !== due_result.slot) begin
          $display("%0t: nearest_index expected %0d got %0d", $time,
                   due_result.slot, seen_result.slot);
          result_mismatches++;
        end
        if (seen_result.dist_sq !== due_result.dist_sq) begin
          $display("%0t: nearest_dist_sq expected %0d got %0d", $time,
                   due_result.dist_sq, seen_result.dist_sq);
          result_mismatches++;
        end
      end
    end
  end

  // Watchdog: a full scan is the longest stretch with no transaction on any port, so a
  // silence several times that long means the block has hung.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles, %0d results outstanding", $time,
               stall_cycles, pending_results.size());
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    logic [APB_DATA_W-1:0] readback;
    plan_row_t             row;
    int                    missing;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // The register must come out of reset at its documented value.
    apb_read(NODE_COUNT_ADDR, readback);
    if (readback !== APB_DATA_W'(NODE_COUNT_RESET)) begin
      $display("%0t: node_count after reset expected %0d got %0d", $time,
               NODE_COUNT_RESET, readback);
      register_mismatches++;
    end
    count_setting = NODE_COUNT_RESET;

    for (int r = 0; r < PLAN_ROWS; r++) begin
      row = directed_plan[r];
      if (row.op == ROW_WRITE) begin
        program_count(row.addr, row.value);
      end else begin
        send_item(row.kind, row.slot, row.x, row.y, row.typed, row.want);
      end
    end

    // Random phases over small node counts; one of them runs with no idling at all.
    for (int p = 0; p < 8; p++) begin
      calm = (p == 3);
      run_phase(phase_counts[p]);
    end
    calm = 1'b0;

    quiesce(DRAIN_CYCLES);
    missing = pending_results.size();
    if (missing != 0) begin
      $display("%0t: %0d expected results never arrived", $time, missing);
    end

    $display("Ran %0d node loads and %0d queries over %0d register writes,",
             load_total, query_total, write_total);
    $display("with node counts from 0 to 64; compared %0d results: %0d register and %0d result mismatches.",
             checked_total, register_mismatches, result_mismatches + missing);
    if (register_mismatches + result_mismatches + missing == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
